/* sv/tile_flip_rotate_engine_defines.svh */
// Assertion macros for the tile flip and rotate engine.
// Used by the top level; depends on nothing else.
`ifndef TILE_FLIP_ROTATE_ENGINE_DEFINES_SVH
`define TILE_FLIP_ROTATE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFRE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tfre_pkg.sv */
// Shared codes and constants of the tile flip and rotate engine.
// Depends on nothing; used by tile_flip_rotate_engine.
package tfre_pkg;

    // Width of the side_log register and of the level field.
    localparam int SL_W = 3;
    localparam logic [SL_W-1:0] SIDE_LOG_RESET = 3'd7;

    // Register index of side_log on the configuration port.
    localparam logic REG_SIDE_LOG = 1'b0;

    // Transaction kinds carried by func.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_OP    = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // Operation codes.
    localparam logic [2:0] OP_TILE_VFLIP = 3'd0;
    localparam logic [2:0] OP_TILE_HFLIP = 3'd1;
    localparam logic [2:0] OP_TILE_ROTR  = 3'd2;
    localparam logic [2:0] OP_TILE_ROTL  = 3'd3;
    localparam logic [2:0] OP_GRID_VFLIP = 3'd4;
    localparam logic [2:0] OP_GRID_HFLIP = 3'd5;
    localparam logic [2:0] OP_GRID_ROTR  = 3'd6;
    localparam logic [2:0] OP_GRID_ROTL  = 3'd7;

endpackage

/* sv/tile_flip_rotate_engine.sv */
// Tile flip and rotate engine: pixel store with whole-image tile operations.
// Depends on tfre_pkg and tile_flip_rotate_engine_defines.svh.
//
// Usage. The input channel (in_valid/in_ready) carries one transaction per
// item: func selects a pixel write, a pixel read or an image operation, with
// row, col, pixel_in, op_code and level as its arguments. Every input
// transaction yields exactly one output transaction (out_valid/out_ready)
// with pixel_out and status; pready is always high. The user sets side_log
// through the APB-style port at byte address 0 only while the block is idle; the block does not enforce it.
//
// Sequence. A write, an unused func, or an operation whose level exceeds
// the side in use goes through the done state to the output register; a
// read passes the read state first. A valid operation sweeps every cell of
// the memory, one cell per cycle, reading the active bank and writing the
// permuted cell into the other bank through a registered read, after
// which the banks swap roles. Only one item is in work at a time: in_ready
// is high only while the controller is idle.
//
// The result sits in an output register, so the next item is accepted while
// a result still waits for the receiver. If the receiver stalls, a finished
// result waits in a pending slot until the output register frees.
//
// Reset clears the control state, selects bank a and sets side_log to 7. The
// memories are not cleared: a pixel must be written before it is read.
module tile_flip_rotate_engine #(
    parameter int MAX_SIDE_LOG = 7,
    parameter int PIXEL_WIDTH  = 16
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [6:0]         row,
    input  logic [6:0]         col,
    input  logic signed [15:0] pixel_in,
    input  logic [2:0]         op_code,
    input  logic [2:0]         level,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pixel_out,
    output logic               status,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "tile_flip_rotate_engine_defines.svh"

    // Address geometry: one memory cell per pixel of the largest image.
    localparam int AW    = MAX_SIDE_LOG;
    localparam int CW    = 2 * AW;
    localparam int DEPTH = 1 << CW;
    localparam int SLW   = tfre_pkg::SL_W;

    // Controller states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_OP    = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Control registers.
    logic [2:0]     state_reg, state_next;
    logic           active_bank_reg, active_bank_next;
    logic [SLW-1:0] side_log_reg, side_log_next;
    logic [CW-1:0]  sweep_reg, sweep_next;
    logic           wv_reg, wv_next;
    logic           out_valid_reg, out_valid_next;

    // Payload registers.
    logic [2:0]     op_reg, op_next;
    logic [AW-1:0]  lvl_mask_reg, lvl_mask_next;
    logic [AW-1:0]  side_mask_reg, side_mask_next;
    logic [CW-1:0]  wa_reg;
    logic [15:0]    pend_pix_reg, pend_pix_next;
    logic           pend_status_reg, pend_status_next;
    logic [15:0]    pixel_out_reg, pixel_out_next;
    logic           status_reg, status_next;

    // Memories and their registered read data.
    logic [PIXEL_WIDTH-1:0] image_bank_a [DEPTH];
    logic [PIXEL_WIDTH-1:0] image_bank_b [DEPTH];
    logic [PIXEL_WIDTH-1:0] a_rdata_reg, b_rdata_reg;

    logic                   in_fire, cfg_write, out_load, level_bad;
    logic [SLW-1:0]         eff_sl;
    logic [CW-1:0]          pix_addr, raddr, map_addr;
    logic [PIXEL_WIDTH-1:0] src_rdata, pix_wdata;
    logic                   a_we, b_we;
    logic [CW-1:0]          a_waddr, b_waddr;
    logic [PIXEL_WIDTH-1:0] a_wdata, b_wdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign status    = status_reg;
    assign pready    = 1'b1;

    // Configuration port: only side_log exists, at register index 0.
    assign cfg_write = psel && penable && pwrite && (paddr[2] == tfre_pkg::REG_SIDE_LOG);
    assign prdata    = (paddr[2] == tfre_pkg::REG_SIDE_LOG) ? 32'(side_log_reg) : 32'd0;

    // A side_log beyond the memory's side saturates.
    assign eff_sl    = (int'(side_log_reg) > MAX_SIDE_LOG) ? SLW'(MAX_SIDE_LOG)
                                                            : side_log_reg;
    assign level_bad = (level > eff_sl);

    assign pix_addr  = {AW'(row), AW'(col)};
    assign pix_wdata = PIXEL_WIDTH'(pixel_in);
    assign raddr     = (state_reg == ST_OP) ? sweep_reg : pix_addr;
    assign src_rdata = active_bank_reg ? b_rdata_reg : a_rdata_reg;

    // Destination of the swept cell. Row and column bits above the tile
    // select the tile, the bits below it address inside the tile; cells
    // outside the image in use are copied in place.
    always_comb
    begin
        logic [AW-1:0] r, c, m, hm, dr, dc;
        r  = sweep_reg[CW-1:AW];
        c  = sweep_reg[AW-1:0];
        m  = lvl_mask_reg;
        hm = side_mask_reg & ~lvl_mask_reg;
        dr = r;
        dc = c;
        unique case (op_reg)
            tfre_pkg::OP_TILE_VFLIP: dr = r ^ m;
            tfre_pkg::OP_TILE_HFLIP: dc = c ^ m;
            tfre_pkg::OP_TILE_ROTR:
            begin
                dr = (r & ~m) | (c & m);
                dc = (c & ~m) | (~r & m);
            end
            tfre_pkg::OP_TILE_ROTL:
            begin
                dr = (r & ~m) | (~c & m);
                dc = (c & ~m) | (r & m);
            end
            tfre_pkg::OP_GRID_VFLIP: dr = r ^ hm;
            tfre_pkg::OP_GRID_HFLIP: dc = c ^ hm;
            tfre_pkg::OP_GRID_ROTR:
            begin
                dr = (c & ~m) | (r & m);
                dc = ((r & ~m) ^ hm) | (c & m);
            end
            tfre_pkg::OP_GRID_ROTL:
            begin
                dr = ((c & ~m) ^ hm) | (r & m);
                dc = (r & ~m) | (c & m);
            end
        endcase
        if (((r & ~side_mask_reg) != '0) || ((c & ~side_mask_reg) != '0))
        begin
            dr = r;
            dc = c;
        end
        map_addr = {dr, dc};
    end

    // Bank write ports: pixel writes go to the active bank, sweep writes to
    // the other one.
    always_comb
    begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        a_waddr = pix_addr;
        b_waddr = pix_addr;
        a_wdata = pix_wdata;
        b_wdata = pix_wdata;
        if (in_fire && (func == tfre_pkg::FUNC_WRITE))
        begin
            a_we = !active_bank_reg;
            b_we = active_bank_reg;
        end
        else if (wv_reg)
        begin
            a_we    = active_bank_reg;
            b_we    = !active_bank_reg;
            a_waddr = wa_reg;
            b_waddr = wa_reg;
            a_wdata = src_rdata;
            b_wdata = src_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            image_bank_a[a_waddr] <= a_wdata;
        end
        a_rdata_reg <= image_bank_a[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            image_bank_b[b_waddr] <= b_wdata;
        end
        b_rdata_reg <= image_bank_b[raddr];
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        active_bank_next = active_bank_reg;
        side_log_next    = side_log_reg;
        sweep_next       = sweep_reg;
        wv_next          = 1'b0;
        op_next          = op_reg;
        lvl_mask_next    = lvl_mask_reg;
        side_mask_next   = side_mask_reg;
        pend_pix_next    = pend_pix_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        pixel_out_next   = pixel_out_reg;
        status_next      = status_reg;
        out_load         = 1'b0;

        if (cfg_write)
        begin
            side_log_next = pwdata[SLW-1:0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pend_pix_next    = 16'd0;
                    pend_status_next = 1'b0;
                    state_next       = ST_DONE;
                    if (func == tfre_pkg::FUNC_READ)
                    begin
                        state_next = ST_RD;
                    end
                    else if (func == tfre_pkg::FUNC_OP)
                    begin
                        if (level_bad)
                        begin
                            pend_status_next = 1'b1;
                        end
                        else
                        begin
                            op_next        = op_code;
                            lvl_mask_next  = ~({AW{1'b1}} << level);
                            side_mask_next = ~({AW{1'b1}} << eff_sl);
                            sweep_next     = '0;
                            state_next     = ST_OP;
                        end
                    end
                end
            end
            ST_RD:
            begin
                pend_pix_next = 16'($signed(src_rdata));
                state_next    = ST_DONE;
            end
            ST_OP:
            begin
                wv_next    = 1'b1;
                sweep_next = sweep_reg + CW'(1);
                if (&sweep_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last cell is written this cycle; then the banks swap.
                active_bank_next = !active_bank_reg;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            pixel_out_next = pend_pix_reg;
            status_next    = pend_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_bank_reg <= 1'b0;
            side_log_reg    <= tfre_pkg::SIDE_LOG_RESET;
            sweep_reg       <= '0;
            wv_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            active_bank_reg <= active_bank_next;
            side_log_reg    <= side_log_next;
            sweep_reg       <= sweep_next;
            wv_reg          <= wv_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        lvl_mask_reg    <= lvl_mask_next;
        side_mask_reg   <= side_mask_next;
        wa_reg          <= map_addr;
        pend_pix_reg    <= pend_pix_next;
        pend_status_reg <= pend_status_next;
        pixel_out_reg   <= pixel_out_next;
        status_reg      <= status_next;
    end

    // The source bank must not change while the sweep reads it.
    `TFRE_ASSERT_NEXT(a_bank_stable_in_sweep, clk, rst_n,
        state_reg == ST_OP, $stable(active_bank_reg),
        "active bank changed during a sweep")
    // Sweep writes happen only while a sweep or its drain is running.
    `TFRE_ASSERT_IMPL(a_sweep_write_window, clk, rst_n,
        wv_reg, state_reg == ST_OP || state_reg == ST_DRAIN,
        "sweep write outside a sweep")
    // A rejected operation leaves the image as it was and finishes at once.
    `TFRE_ASSERT_NEXT(a_bad_level_ignored, clk, rst_n,
        in_fire && func == tfre_pkg::FUNC_OP && level_bad,
        state_reg == ST_DONE && $stable(active_bank_reg) && pend_status_reg,
        "rejected operation not ignored")
    // A finished result reaches the output register as soon as it is free.
    `TFRE_ASSERT_NEXT(a_result_delivery, clk, rst_n,
        state_reg == ST_DONE && (!out_valid_reg || out_ready),
        out_valid_reg && state_reg == ST_IDLE,
        "finished result not delivered")

endmodule

/* bench/tile_flip_rotate_engine_checker.sv */
`timescale 1ns / 100ps
// Checker for the tile flip and rotate engine: watches both channels and the
// configuration port, predicts every result and compares it. Needs tfre_pkg.
module tile_flip_rotate_engine_checker #(
    parameter int MAX_SIDE_LOG = 7
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [1:0]          func,
    input  logic [6:0]          row,
    input  logic [6:0]          col,
    input  logic signed [15:0]  pixel_in,
    input  logic [2:0]          op_code,
    input  logic [2:0]          level,

    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [15:0]  pixel_out,
    input  logic                status,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,

    output int                  fail_count,
    output int                  outstanding,
    output bit [(1 << (2*MAX_SIDE_LOG))-1:0] known_now
);

    localparam int MEM_SIDE  = 1 << MAX_SIDE_LOG;
    localparam int MEM_CELLS = MEM_SIDE * MEM_SIDE;

    typedef struct packed {
        logic signed [15:0] pixel;
        logic               status;
    } engine_result_t;

    // Mirror of the two ping-pong banks, with a flag per cell that tells
    // whether it holds a written value.
    logic [15:0]                   pixel_store [2][MEM_CELLS];
    bit [MEM_CELLS-1:0]            cell_written [2];
    bit                            front_bank;
    logic [tfre_pkg::SL_W-1:0]     side_log;
    engine_result_t                awaited_results [$];

    assign known_now = cell_written[front_bank];

    initial begin
        fail_count  = 0;
        outstanding = 0;
        front_bank  = 1'b0;
        side_log    = tfre_pkg::SIDE_LOG_RESET;
    end

    // Rewrites the image from the front bank into the back bank, then swaps; does nothing if lvl exceeds the side.
    task automatic retile_image(input logic [2:0] op, input logic [2:0] lvl,
                                output logic ignored);
        int sl, side, t, nt, r, c, ti, tj, k, l, dr, dc, back;
        sl = (int'(side_log) > MAX_SIDE_LOG) ? MAX_SIDE_LOG : int'(side_log);
        ignored = (int'(lvl) > sl);
        if (ignored)
            return;
        side = 1 << sl;
        t    = 1 << lvl;
        nt   = side >> lvl;
        back = front_bank ? 0 : 1;
        for (r = 0; r < MEM_CELLS; r++)
            pixel_store[back][r] = pixel_store[front_bank][r];
        cell_written[back] = cell_written[front_bank];
        for (r = 0; r < side; r++) begin
            for (c = 0; c < side; c++) begin
                ti = r >> lvl;
                tj = c >> lvl;
                k  = r & (t - 1);
                l  = c & (t - 1);
                dr = r;
                dc = c;
                case (op)
                    tfre_pkg::OP_TILE_VFLIP: dr = ti * t + (t - 1 - k);
                    tfre_pkg::OP_TILE_HFLIP: dc = tj * t + (t - 1 - l);
                    tfre_pkg::OP_TILE_ROTR:
                    begin
                        dr = ti * t + l;
                        dc = tj * t + (t - 1 - k);
                    end
                    tfre_pkg::OP_TILE_ROTL:
                    begin
                        dr = ti * t + (t - 1 - l);
                        dc = tj * t + k;
                    end
                    tfre_pkg::OP_GRID_VFLIP: dr = (nt - 1 - ti) * t + k;
                    tfre_pkg::OP_GRID_HFLIP: dc = (nt - 1 - tj) * t + l;
                    tfre_pkg::OP_GRID_ROTR:
                    begin
                        dr = tj * t + k;
                        dc = (nt - 1 - ti) * t + l;
                    end
                    tfre_pkg::OP_GRID_ROTL:
                    begin
                        dr = (nt - 1 - tj) * t + k;
                        dc = ti * t + l;
                    end
                    default: ;
                endcase
                pixel_store[back][dr * MEM_SIDE + dc] =
                    pixel_store[front_bank][r * MEM_SIDE + c];
                cell_written[back][dr * MEM_SIDE + dc] =
                    cell_written[front_bank][r * MEM_SIDE + c];
            end
        end
        front_bank = ~front_bank;
    endtask

    task automatic predict_transaction();
        engine_result_t res;
        int             mem_idx;
        logic           ignored;
        res     = '0;
        mem_idx = int'(row) * MEM_SIDE + int'(col);
        case (func)
            tfre_pkg::FUNC_WRITE:
            begin
                pixel_store[front_bank][mem_idx] = pixel_in;
                cell_written[front_bank][mem_idx] = 1'b1;
            end
            tfre_pkg::FUNC_READ: res.pixel = pixel_store[front_bank][mem_idx];
            tfre_pkg::FUNC_OP:
            begin
                retile_image(op_code, level, ignored);
                res.status = ignored;
            end
            default: ;
        endcase
        awaited_results.push_back(res);
    endtask

    always @(posedge clk) begin
        engine_result_t want;
        if (!rst_n) begin
            awaited_results.delete();
            front_bank      = 1'b0;
            side_log        = tfre_pkg::SIDE_LOG_RESET;
            cell_written[0] = '0;
            cell_written[1] = '0;
        end else begin
            if (out_valid && out_ready) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no transaction awaiting it: expected none, %s",
                             $time, "actual:");
                    $display("%0t:   actual pixel_out %0d status %0d",
                             $time, pixel_out, status);
                end else begin
                    want = awaited_results.pop_front();
                    if (pixel_out !== want.pixel) begin
                        fail_count++;
                        $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                                 $time, want.pixel, pixel_out);
                    end
                    if (status !== want.status) begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, status);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_transaction();
            if (psel && penable && pwrite && pready &&
                ((paddr >> 2) == 3'(tfre_pkg::REG_SIDE_LOG)))
                side_log = pwdata[tfre_pkg::SL_W-1:0];
        end
        outstanding = awaited_results.size();
    end

endmodule

/* bench/tile_flip_rotate_engine_tb.sv */
`timescale 1ns / 100ps
// Top of the tile flip and rotate engine bench: clock, reset, stimulus and
// verdict. Needs tfre_pkg, the engine RTL and tile_flip_rotate_engine_checker.
module tile_flip_rotate_engine_tb;

    // Every valid operation sweeps all 16384 cells of the memory, so the run
    // is dominated by operations, of which there are about 25; the limit
    // leaves a wide margin for them.
    localparam int LIMIT_CYCLES   = 4_000_000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_OPS_MAX = 16;
    localparam int ITEMS_PER_PHASE = 7;
    localparam int RECENT_DEPTH   = 32;
    localparam int MEM_CELLS      = 1 << 14;

    logic               clk;
    logic               rst_n;

    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [15:0] pixel_in;
    logic [2:0]         op_code;
    logic [2:0]         level;

    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] pixel_out;
    logic               status;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int                 fail_count;
    int                 outstanding;
    bit [MEM_CELLS-1:0] known_now;

    int                 cycle_count;
    int                 rx_hold_req;
    bit                 no_gaps;
    int                 ops_left;
    logic [2:0]         side_log_now;
    logic [13:0]        recent_cells [$];

    // Run statistics for the closing summary.
    int                 n_items;
    int                 n_reads;
    int                 n_ops;
    int                 n_ignored;
    int                 n_settings;

    tile_flip_rotate_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .row       (row),
        .col       (col),
        .pixel_in  (pixel_in),
        .op_code   (op_code),
        .level     (level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // The checker sees exactly what the block sees. It also tells the
    // stimulus which cells of the front bank hold written values, so that a
    // read of a never written cell is never issued, even after operations
    // have moved the contents around.
    tile_flip_rotate_engine_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .row         (row),
        .col         (col),
        .pixel_in    (pixel_in),
        .op_code     (op_code),
        .level       (level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .status      (status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .known_now   (known_now)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run stopped after %0d cycles with %0d results outstanding",
                 $time, cycle_count, outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Receiver. It alternates between stretches where it always takes the
    // result and stretches with random stalls. When the stimulus asks for a
    // hold-off, it refuses results long enough that the output register and
    // the pending slot fill and the block has to stall its input.
    initial begin : receiver
        int stall_left;
        int mode_left;
        int rx_hold_seen;
        bit eager;
        stall_left   = 0;
        mode_left    = 0;
        rx_hold_seen = 0;
        eager        = 1'b0;
        out_ready    = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req != rx_hold_seen) begin
                rx_hold_seen = rx_hold_req;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    eager     = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(20, 100);
                end
                mode_left--;
                if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= 1'b0;
                end else if (eager || $urandom_range(0, 99) < 65) begin
                    out_ready <= 1'b1;
                end else begin
                    stall_left = gap_length();
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // Offers one transaction and returns at the falling edge after it was
    // accepted. With no gap, valid simply stays high into the next item.
    task automatic send_transaction(input logic [1:0] f, input logic [6:0] r,
                                    input logic [6:0] c, input logic [15:0] pix,
                                    input logic [2:0] op, input logic [2:0] lvl);
        int gap;
        gap = no_gaps ? 0 : gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        row      <= r;
        col      <= c;
        pixel_in <= pix;
        op_code  <= op;
        level    <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        n_items++;
        if (f == tfre_pkg::FUNC_READ)
            n_reads++;
        if (f == tfre_pkg::FUNC_OP) begin
            if (lvl > side_log_now)
                n_ignored++;
            else
                n_ops++;
        end
    endtask

    // A pixel write whose address is remembered as a likely target for reads.
    task automatic write_pixel(input logic [6:0] r, input logic [6:0] c,
                               input logic [15:0] pix);
        send_transaction(tfre_pkg::FUNC_WRITE, r, c, pix, 3'($urandom()), 3'($urandom()));
        recent_cells.push_back({r, c});
        if (recent_cells.size() > RECENT_DEPTH)
            void'(recent_cells.pop_front());
    endtask

    // The sender stops and waits until every result is back, then lets the
    // block settle.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write through the APB-style port: setup, then access.
    // The upper data bits are random; only the low three reach side_log.
    task automatic write_side_log(input logic [2:0] value);
        logic [31:0] data;
        data      = $urandom();
        data[2:0] = value;
        wait_all_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(tfre_pkg::REG_SIDE_LOG) << 2;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        side_log_now = value;
        n_settings++;
    endtask

    // Writes every pixel of the image in use, so that operations keep the
    // whole image readable.
    task automatic fill_image();
        int side;
        int r;
        int c;
        side = 1 << side_log_now;
        for (r = 0; r < side; r++)
            for (c = 0; c < side; c++)
                write_pixel(7'(r), 7'(c), 16'($urandom()));
    endtask

    // Looks for a written cell: recent write targets first, then random
    // cells of the image, then anywhere in the memory.
    function automatic bit pick_known_cell(input int s, output logic [6:0] r,
                                           output logic [6:0] c);
        logic [13:0] mem_idx;
        int          side;
        int          i;
        side = 1 << s;
        for (i = 0; i < 24; i++) begin
            if (i < 8 && recent_cells.size() > 0)
                mem_idx = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
            else if (i < 20)
                mem_idx = {7'($urandom_range(0, side - 1)), 7'($urandom_range(0, side - 1))};
            else
                mem_idx = 14'($urandom());
            if (known_now[mem_idx]) begin
                r = mem_idx[13:7];
                c = mem_idx[6:0];
                return 1'b1;
            end
        end
        r = '0;
        c = '0;
        return 1'b0;
    endfunction

    // One random transaction for the image side 2^s. Writes land mostly in
    // the image so that operations move them; a fifth go anywhere in the
    // memory, outside the image included. Unused fields carry random bits.
    task automatic random_item(input int s);
        logic [6:0] r;
        logic [6:0] c;
        int         side;
        int         p;
        side = 1 << s;
        p    = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) begin
            r = 7'($urandom());
            c = 7'($urandom());
        end else begin
            r = 7'($urandom_range(0, side - 1));
            c = 7'($urandom_range(0, side - 1));
        end
        if (p < 40) begin
            write_pixel(r, c, 16'($urandom()));
        end else if (p < 75) begin
            if (pick_known_cell(s, r, c))
                send_transaction(tfre_pkg::FUNC_READ, r, c, 16'($urandom()),
                                 3'($urandom()), 3'($urandom()));
            else
                write_pixel(r, c, 16'($urandom()));
        end else if (p < 88 && ops_left > 0) begin
            ops_left--;
            send_transaction(tfre_pkg::FUNC_OP, 7'($urandom()), 7'($urandom()),
                             16'($urandom()), 3'($urandom_range(0, 7)),
                             3'($urandom_range(0, s)));
        end else if (p < 94 && s < 7) begin
            // Tile larger than the image: the block must leave it alone.
            send_transaction(tfre_pkg::FUNC_OP, 7'($urandom()), 7'($urandom()),
                             16'($urandom()), 3'($urandom_range(0, 7)),
                             3'($urandom_range(s + 1, 7)));
        end else begin
            send_transaction(tfre_pkg::FUNC_NONE, 7'($urandom()), 7'($urandom()),
                             16'($urandom()), 3'($urandom()), 3'($urandom()));
        end
    endtask

    initial begin : stimulus
        logic [2:0] phase_logs [5];
        int         p;
        int         i;
        in_valid     = 1'b0;
        func         = tfre_pkg::FUNC_WRITE;
        row          = '0;
        col          = '0;
        pixel_in     = '0;
        op_code      = tfre_pkg::OP_TILE_VFLIP;
        level        = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;
        no_gaps      = 1'b0;
        rx_hold_req  = 0;
        ops_left     = RANDOM_OPS_MAX;
        side_log_now = tfre_pkg::SIDE_LOG_RESET;
        n_items      = 0;
        n_reads      = 0;
        n_ops        = 0;
        n_ignored    = 0;
        n_settings   = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset side of 128: pixel extremes and a random
        // value in the four corners of the memory, reads back, an unused func, and
        // a rotation of the whole image as one tile, which cycles the four corners.
        write_pixel(7'd0, 7'd0, 16'h8000);
        write_pixel(7'd127, 7'd127, 16'h7fff);
        write_pixel(7'd0, 7'd127, 16'($urandom()));
        write_pixel(7'd127, 7'd0, 16'hffff);
        send_transaction(tfre_pkg::FUNC_READ, 7'd0, 7'd0, 16'($urandom()), 3'd7, 3'd7);
        send_transaction(tfre_pkg::FUNC_READ, 7'd127, 7'd127, 16'($urandom()), 3'd0, 3'd0);
        send_transaction(tfre_pkg::FUNC_NONE, 7'd127, 7'd127, 16'hffff, 3'd7, 3'd7);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_TILE_ROTR,
                         3'd7);
        send_transaction(tfre_pkg::FUNC_READ, 7'd0, 7'd127, 16'h0000, 3'd0, 3'd0);
        send_transaction(tfre_pkg::FUNC_READ, 7'd127, 7'd0, 16'h0000, 3'd0, 3'd0);

        // A 2 by 2 image: every operation, the tile ones with the whole image as
        // the tile and the grid ones with single pixels. The corners other than
        // (0, 0) now lie outside the image and must stay where they are.
        write_side_log(3'd1);
        fill_image();
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_TILE_VFLIP,
                         3'd1);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_TILE_HFLIP,
                         3'd1);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_TILE_ROTR,
                         3'd1);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_TILE_ROTL,
                         3'd1);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_GRID_VFLIP,
                         3'd0);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_GRID_HFLIP,
                         3'd0);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_GRID_ROTR,
                         3'd0);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_GRID_ROTL,
                         3'd0);
        send_transaction(tfre_pkg::FUNC_OP, 7'd0, 7'd0, 16'h0000, tfre_pkg::OP_GRID_ROTL,
                         3'd7);
        send_transaction(tfre_pkg::FUNC_READ, 7'd0, 7'd0, 16'h0000, 3'd0, 3'd0);
        send_transaction(tfre_pkg::FUNC_READ, 7'd127, 7'd127, 16'h0000, 3'd0, 3'd0);

        // Random part, one phase per image side. Small sides are filled
        // first so that operations keep every pixel of the image readable.
        phase_logs[0] = 3'd3;
        phase_logs[1] = 3'd2;
        phase_logs[2] = 3'd7;
        phase_logs[3] = 3'd0;
        phase_logs[4] = 3'($urandom_range(0, 7));
        for (p = 0; p < 5; p++) begin
            write_side_log(phase_logs[p]);
            if (phase_logs[p] <= 3'd2)
                fill_image();
            if (p == 0) begin
                // Long receiver hold-off while writes keep coming back to
                // back, so the block fills and stalls its input.
                rx_hold_req++;
                no_gaps = 1'b1;
                for (i = 0; i < 12; i++)
                    write_pixel(7'($urandom_range(0, 7)), 7'($urandom_range(0, 7)),
                                16'($urandom()));
                wait_all_results();
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i % 5 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                random_item(phase_logs[p]);
                if (p == 1 && i == ITEMS_PER_PHASE / 2)
                    wait_all_results();
            end
            no_gaps = 1'b0;
        end

        wait_all_results();
        $display("Ran %0d transactions: %0d reads, %0d image operations, %0d with oversized tiles,",
                 n_items, n_reads, n_ops, n_ignored);
        $display("over %0d side_log settings in %0d cycles.", n_settings, cycle_count);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
